>>> hw/rtl/ams_pkg.sv
`timescale 1ns / 1ps

package ams_pkg;

  // Operating modes
  typedef enum logic [2:0] {
    MODE_STARTUP = 3'd0,
    MODE_TEST    = 3'd1,
    MODE_WAITING = 3'd2,
    MODE_RUNNING = 3'd3,
    MODE_ISP     = 3'd4,
    MODE_FAULT   = 3'd5
  } mode_e;

  // Command codes
  localparam logic [2:0] CMD_SERVICE   = 3'd0;
  localparam logic [2:0] CMD_INIT_DONE = 3'd1;
  localparam logic [2:0] CMD_CAMERA    = 3'd2;
  localparam logic [2:0] CMD_STOP      = 3'd3;
  localparam logic [2:0] CMD_RACE      = 3'd4;
  localparam logic [2:0] CMD_FAULT     = 3'd5;

  // Action verdicts
  localparam logic [1:0] RES_ACCEPTED  = 2'd0;
  localparam logic [1:0] RES_NOT_READY = 2'd1;
  localparam logic [1:0] RES_DENIED    = 2'd2;

  // Fault codes
  localparam logic [2:0] FAULT_NONE          = 3'd0;
  localparam logic [2:0] FAULT_CAM_STARTUP   = 3'd1;
  localparam logic [2:0] FAULT_BOOT_RETURNED = 3'd4;

  // Status codes
  localparam logic [3:0] ST_INIT          = 4'd0;
  localparam logic [3:0] ST_TEST_DISARMED = 4'd1;
  localparam logic [3:0] ST_TEST_CENTRE   = 4'd2;
  localparam logic [3:0] ST_TEST_ARMED    = 4'd3;
  localparam logic [3:0] ST_WAIT_CAMERA   = 4'd4;
  localparam logic [3:0] ST_RACE_READY    = 4'd5;
  localparam logic [3:0] ST_RACE_RUNNING  = 4'd6;
  localparam logic [3:0] ST_ENTERING_BOOT = 4'd7;
  localparam logic [3:0] ST_SAFE_FAULT    = 4'd12;

  // Configuration register indexes and reset values
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_ISP_SETTLE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ISP_MAX_WAIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_POT_LOW      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_POT_HIGH     = 3'd3;

  localparam logic [15:0] ISP_SETTLE_RST   = 16'd100;
  localparam logic [15:0] ISP_MAX_WAIT_RST = 16'd500;
  localparam logic [11:0] POT_LOW_RST      = 12'd1843;
  localparam logic [11:0] POT_HIGH_RST     = 12'd2252;

  typedef struct packed {
    mode_e       mode;
    logic [2:0]  fault;
    logic        cam;
    logic        rdy;
    logic        armed;
    logic        pend;
    logic [31:0] isp_t;
  } st_t;

  typedef struct packed {
    logic motor;
    logic servo;
    logic boot;
  } strb_t;

  typedef struct packed {
    st_t   st;
    strb_t sb;
  } work_t;

  // Mode change: strobes only once the platform is up; clears arming.
  function automatic work_t change_mode(work_t w, mode_e m);
    work_t r;
    r = w;
    if (w.st.mode != m) begin
      if (w.st.rdy) begin
        r.sb.motor = 1'b1;
        r.sb.servo = 1'b1;
      end
      r.st.armed = 1'b0;
      r.st.pend  = 1'b0;
      r.st.mode  = m;
    end
    return r;
  endfunction

  function automatic logic [3:0] status_code(st_t s);
    logic [3:0] code;
    unique case (s.mode)
      MODE_TEST:    code = s.armed ? ST_TEST_ARMED :
                           (s.pend ? ST_TEST_CENTRE : ST_TEST_DISARMED);
      MODE_WAITING: code = s.cam ? ST_RACE_READY : ST_WAIT_CAMERA;
      MODE_RUNNING: code = ST_RACE_RUNNING;
      MODE_ISP:     code = ST_ENTERING_BOOT;
      MODE_FAULT: begin
        if (s.fault >= FAULT_CAM_STARTUP && s.fault <= FAULT_BOOT_RETURNED) begin
          code = ST_ENTERING_BOOT + {1'b0, s.fault};
        end else begin
          code = ST_SAFE_FAULT;
        end
      end
      default:      code = ST_INIT;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/actuator_mode_supervisor_top.sv
`timescale 1ns / 1ps

// Actuator mode supervisor.
// Input channel (in_valid_i / in_stall_o) carries one command beat per item:
// service tick, init done, camera frame, stop, race start or fault entry,
// plus switch, button, pot, host link and time fields.
// Output channel (out_valid_o / out_stall_i) returns exactly one result beat
// per command: mode, status, action verdict, strobes and status flags.
// A beat moves on a rising edge with valid high and stall low.
// The input register feeds the mode update logic, which loads the result
// register. Throughput: one item per cycle while the receiver does not stall,
// set by the state update loop on the mode registers.
// When the receiver stalls, the result register holds; one more item may sit
// in the input register, after which in_stall_o rises.
// Config port: cfg_valid_i/cfg_ready_o with index and data; always ready.
// Write only while no item is in flight.
// Reset (rst_ni low, async): mode startup, all flags and fault cleared,
// config registers back to their defaults, both pipeline stages empty.

module actuator_mode_supervisor_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ams_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ams_pkg::CfgDataW-1:0] cfg_data_i,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   cmd_i,
  input  logic                         test_switch_i,
  input  logic                         button_release_i,
  input  logic [11:0]                  pot_a_i,
  input  logic [11:0]                  pot_b_i,
  input  logic [11:0]                  pot_c_i,
  input  logic                         isp_request_i,
  input  logic                         tx_idle_i,
  input  logic [31:0]                  now_ms_i,
  input  logic [2:0]                   fault_code_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   mode_o,
  output logic [3:0]                   status_o,
  output logic [1:0]                   action_result_o,
  output logic                         outputs_allowed_o,
  output logic                         motor_disable_o,
  output logic                         servo_center_o,
  output logic                         boot_request_o,
  output logic [2:0]                   fault_o,
  output logic                         camera_seen_o,
  output logic                         test_armed_o,
  output logic                         arm_pending_o
);

  // ---------------- configuration registers ----------------
  logic [15:0] settle_q, max_wait_q;
  logic [11:0] pot_lo_q, pot_hi_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= ams_pkg::ISP_SETTLE_RST;
      max_wait_q <= ams_pkg::ISP_MAX_WAIT_RST;
      pot_lo_q   <= ams_pkg::POT_LOW_RST;
      pot_hi_q   <= ams_pkg::POT_HIGH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ams_pkg::CFG_ISP_SETTLE:   settle_q   <= cfg_data_i;
        ams_pkg::CFG_ISP_MAX_WAIT: max_wait_q <= cfg_data_i;
        ams_pkg::CFG_POT_LOW:      pot_lo_q   <= cfg_data_i[11:0];
        ams_pkg::CFG_POT_HIGH:     pot_hi_q   <= cfg_data_i[11:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------- pipeline handshake ----------------
  logic in_vld_q, out_vld_q;
  logic advance;   // input stage beat moves into the result stage

  assign advance    = in_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign out_valid_o = out_vld_q;

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---------------- input register ----------------
  logic [2:0]  cmd_q;
  logic        tsw_q, btn_q, isp_req_q, tx_idle_q;
  logic [11:0] pot_a_q, pot_b_q, pot_c_q;
  logic [31:0] now_q;
  logic [2:0]  fcode_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q     <= cmd_i;
      tsw_q     <= test_switch_i;
      btn_q     <= button_release_i;
      pot_a_q   <= pot_a_i;
      pot_b_q   <= pot_b_i;
      pot_c_q   <= pot_c_i;
      isp_req_q <= isp_request_i;
      tx_idle_q <= tx_idle_i;
      now_q     <= now_ms_i;
      fcode_q   <= fault_code_i;
    end
  end

  // ---------------- supervisor state ----------------
  ams_pkg::st_t st_q, st_d;
  ams_pkg::work_t w;
  logic [1:0]  result;
  logic [31:0] elapsed;
  logic        centred;

  assign centred = (pot_a_q > pot_lo_q) && (pot_a_q < pot_hi_q) &&
                   (pot_b_q > pot_lo_q) && (pot_b_q < pot_hi_q) &&
                   (pot_c_q > pot_lo_q) && (pot_c_q < pot_hi_q);

  always_comb begin
    w.st    = st_q;
    w.sb    = '0;
    result  = ams_pkg::RES_ACCEPTED;
    elapsed = '0;
    unique case (cmd_q)
      ams_pkg::CMD_SERVICE: begin
        if (st_q.mode == ams_pkg::MODE_FAULT) begin
          // safe fault: keep the motor held off, nothing else moves
          w.sb.motor = 1'b1;
        end else begin
          if (isp_req_q) begin
            w = ams_pkg::change_mode(w, ams_pkg::MODE_ISP);
            w.sb.motor = 1'b1;
            w.sb.servo = 1'b1;
            w.st.isp_t = now_q;
          end
          if (w.st.mode == ams_pkg::MODE_ISP) begin
            elapsed    = now_q - w.st.isp_t;
            w.sb.motor = 1'b1;
            w.sb.servo = 1'b1;
            if (elapsed >= {16'd0, settle_q} &&
                (tx_idle_q || elapsed >= {16'd0, max_wait_q})) begin
              w.sb.boot  = 1'b1;
              w.st.fault = ams_pkg::FAULT_BOOT_RETURNED;
              w = ams_pkg::change_mode(w, ams_pkg::MODE_FAULT);
            end
          end else if (tsw_q) begin
            w = ams_pkg::change_mode(w, ams_pkg::MODE_TEST);
            if (btn_q) begin
              // release toggles: disarm if armed or pending, else start arming
              if (w.st.armed || w.st.pend) begin
                w.st.armed = 1'b0;
                w.st.pend  = 1'b0;
                w.sb.motor = 1'b1;
              end else begin
                w.st.pend = 1'b1;
              end
            end
            if (w.st.pend && centred) begin
              w.st.pend  = 1'b0;
              w.st.armed = 1'b1;
            end
          end else begin
            if (w.st.mode == ams_pkg::MODE_TEST) begin
              w = ams_pkg::change_mode(w, ams_pkg::MODE_WAITING);
            end
            if (w.st.mode == ams_pkg::MODE_RUNNING) begin
              if (btn_q) begin
                w = ams_pkg::change_mode(w, ams_pkg::MODE_WAITING);
              end
            end else if (w.st.mode == ams_pkg::MODE_WAITING && btn_q && w.st.cam) begin
              w = ams_pkg::change_mode(w, ams_pkg::MODE_RUNNING);
            end
          end
        end
      end
      ams_pkg::CMD_INIT_DONE: begin
        w.st       = '0;
        w.st.mode  = ams_pkg::MODE_STARTUP;
        w.st.fault = ams_pkg::FAULT_NONE;
        w.st.rdy   = 1'b1;
        w = ams_pkg::change_mode(w, tsw_q ? ams_pkg::MODE_TEST : ams_pkg::MODE_WAITING);
      end
      ams_pkg::CMD_CAMERA: begin
        w.st.cam = 1'b1;
      end
      ams_pkg::CMD_STOP: begin
        w.sb.motor = 1'b1;
        w.sb.servo = 1'b1;
        w.st.armed = 1'b0;
        w.st.pend  = 1'b0;
        if (w.st.mode == ams_pkg::MODE_RUNNING) begin
          w = ams_pkg::change_mode(w, ams_pkg::MODE_WAITING);
        end
      end
      ams_pkg::CMD_RACE: begin
        if (tsw_q || w.st.mode != ams_pkg::MODE_WAITING) begin
          result = ams_pkg::RES_DENIED;
        end else if (!w.st.cam) begin
          result = ams_pkg::RES_NOT_READY;
        end else begin
          w = ams_pkg::change_mode(w, ams_pkg::MODE_RUNNING);
        end
      end
      ams_pkg::CMD_FAULT: begin
        // fault codes above FAULT_BOOT_RETURNED latch as none
        w.st.fault = (fcode_q <= ams_pkg::FAULT_BOOT_RETURNED) ? fcode_q
                                                                : ams_pkg::FAULT_NONE;
        w = ams_pkg::change_mode(w, ams_pkg::MODE_FAULT);
      end
      default: begin
        result = ams_pkg::RES_DENIED;
      end
    endcase
    st_d = w.st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{mode: ams_pkg::MODE_STARTUP, fault: ams_pkg::FAULT_NONE,
                cam: 1'b0, rdy: 1'b0, armed: 1'b0, pend: 1'b0, isp_t: 32'd0};
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i) begin
    if (advance) begin
      mode_o            <= st_d.mode;
      status_o          <= ams_pkg::status_code(st_d);
      action_result_o   <= result;
      outputs_allowed_o <= (st_d.mode == ams_pkg::MODE_RUNNING) ||
                           (st_d.mode == ams_pkg::MODE_TEST && st_d.armed);
      motor_disable_o   <= w.sb.motor;
      servo_center_o    <= w.sb.servo;
      boot_request_o    <= w.sb.boot;
      fault_o           <= st_d.fault;
      camera_seen_o     <= st_d.cam;
      test_armed_o      <= st_d.armed;
      arm_pending_o     <= st_d.pend;
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the actuator mode supervisor.
// Every command beat yields exactly one report beat, so the scoreboard is a
// plain FIFO of predicted reports filled as commands are accepted.

module tb_top;
  import ams_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT = 400000;
  // Two-stage pipe; spare time waited after the last report drains.
  localparam int DRAIN_CYCLES = 6;
  localparam int IDLE_PCT = 31;

  // Commands not decoded by the block.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  // Fault codes the package does not name.
  localparam logic [2:0] FAULT_CAM_LOST = 3'd2;
  localparam logic [2:0] FAULT_BAD_CODE = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        test_sw;
    logic        button;
    logic [11:0] pot_a;
    logic [11:0] pot_b;
    logic [11:0] pot_c;
    logic        isp_req;
    logic        tx_idle;
    logic [31:0] now_ms;
    logic [2:0]  fault_code;
  } command_t;

  typedef struct packed {
    mode_e      mode;
    logic [3:0] status;
    logic [1:0] verdict;
    logic       allowed;
    logic       motor;
    logic       servo;
    logic       boot;
    logic [2:0] fault;
    logic       cam;
    logic       armed;
    logic       pend;
  } report_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = CMD_SERVICE;
  logic        test_switch_i = 1'b0;
  logic        button_release_i = 1'b0;
  logic [11:0] pot_a_i = '0;
  logic [11:0] pot_b_i = '0;
  logic [11:0] pot_c_i = '0;
  logic        isp_request_i = 1'b0;
  logic        tx_idle_i = 1'b0;
  logic [31:0] now_ms_i = '0;
  logic [2:0]  fault_code_i = FAULT_NONE;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  mode_o;
  logic [3:0]  status_o;
  logic [1:0]  action_result_o;
  logic        outputs_allowed_o;
  logic        motor_disable_o;
  logic        servo_center_o;
  logic        boot_request_o;
  logic [2:0]  fault_o;
  logic        camera_seen_o;
  logic        test_armed_o;
  logic        arm_pending_o;

  actuator_mode_supervisor_top dut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .test_switch_i     (test_switch_i),
    .button_release_i  (button_release_i),
    .pot_a_i           (pot_a_i),
    .pot_b_i           (pot_b_i),
    .pot_c_i           (pot_c_i),
    .isp_request_i     (isp_request_i),
    .tx_idle_i         (tx_idle_i),
    .now_ms_i          (now_ms_i),
    .fault_code_i      (fault_code_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .mode_o            (mode_o),
    .status_o          (status_o),
    .action_result_o   (action_result_o),
    .outputs_allowed_o (outputs_allowed_o),
    .motor_disable_o   (motor_disable_o),
    .servo_center_o    (servo_center_o),
    .boot_request_o    (boot_request_o),
    .fault_o           (fault_o),
    .camera_seen_o     (camera_seen_o),
    .test_armed_o      (test_armed_o),
    .arm_pending_o     (arm_pending_o)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow supervisor: mirrors mode, flags and register settings.
  // ---------------------------------------------------------------------------
  mode_e       sv_mode = MODE_STARTUP;
  logic [2:0]  sv_fault = FAULT_NONE;
  logic        sv_cam = 1'b0;
  logic        sv_ready = 1'b0;
  logic        sv_armed = 1'b0;
  logic        sv_pend = 1'b0;
  logic [31:0] sv_isp_t = '0;
  logic        st_motor, st_servo, st_boot;

  logic [15:0] cfg_settle = ISP_SETTLE_RST;
  logic [15:0] cfg_max_wait = ISP_MAX_WAIT_RST;
  logic [11:0] cfg_pot_lo = POT_LOW_RST;
  logic [11:0] cfg_pot_hi = POT_HIGH_RST;

  report_t expected_reports[$];
  report_t want_r;
  int      fails = 0;
  int      cycles = 0;

  // Stimulus shaping shared between processes.
  bit          quiet = 1'b0;     // no idling on either side
  int          rx_hold = 0;      // receiver hold-off, counted down below
  logic [31:0] tb_clock_ms = '0; // running millisecond clock for sequences
  bit          tb_switch = 1'b0; // sticky test switch level

  // Any real mode change drops arming; strobes only once the platform is up.
  function automatic void switch_mode(mode_e m);
    if (sv_mode != m) begin
      if (sv_ready) begin
        st_motor = 1'b1;
        st_servo = 1'b1;
      end
      sv_armed = 1'b0;
      sv_pend  = 1'b0;
      sv_mode  = m;
    end
  endfunction

  function automatic bit pot_centred(logic [11:0] v);
    return v > cfg_pot_lo && v < cfg_pot_hi;
  endfunction

  function automatic logic [3:0] status_of();
    logic [3:0] s;
    case (sv_mode)
      MODE_TEST:    s = sv_armed ? ST_TEST_ARMED : (sv_pend ? ST_TEST_CENTRE : ST_TEST_DISARMED);
      MODE_WAITING: s = sv_cam ? ST_RACE_READY : ST_WAIT_CAMERA;
      MODE_RUNNING: s = ST_RACE_RUNNING;
      MODE_ISP:     s = ST_ENTERING_BOOT;
      MODE_FAULT: begin
        // Fault codes 1 to 4 map to their own status, anything else is generic.
        if (sv_fault != FAULT_NONE && sv_fault <= FAULT_BOOT_RETURNED) begin
          s = ST_ENTERING_BOOT + {1'b0, sv_fault};
        end else begin
          s = ST_SAFE_FAULT;
        end
      end
      default:      s = ST_INIT;
    endcase
    return s;
  endfunction

  function automatic void service_tick(command_t c);
    logic [31:0] elapsed;
    // In safe fault a tick only keeps the motor disabled.
    if (sv_mode == MODE_FAULT) begin
      st_motor = 1'b1;
      return;
    end
    if (c.isp_req) begin
      switch_mode(MODE_ISP);
      st_motor = 1'b1;
      st_servo = 1'b1;
      sv_isp_t = c.now_ms;
    end
    if (sv_mode == MODE_ISP) begin
      elapsed = c.now_ms - sv_isp_t; // modulo 2^32
      st_motor = 1'b1;
      st_servo = 1'b1;
      if (elapsed >= {16'b0, cfg_settle} &&
          (c.tx_idle || elapsed >= {16'b0, cfg_max_wait})) begin
        st_boot  = 1'b1;
        sv_fault = FAULT_BOOT_RETURNED;
        switch_mode(MODE_FAULT);
      end
      return;
    end
    if (c.test_sw) begin
      switch_mode(MODE_TEST);
      if (c.button) begin
        if (sv_armed || sv_pend) begin
          sv_armed = 1'b0;
          sv_pend  = 1'b0;
          st_motor = 1'b1;
        end else begin
          sv_pend = 1'b1;
        end
      end
      if (sv_pend && pot_centred(c.pot_a) && pot_centred(c.pot_b) && pot_centred(c.pot_c)) begin
        sv_pend  = 1'b0;
        sv_armed = 1'b1;
      end
      return;
    end
    if (sv_mode == MODE_TEST) switch_mode(MODE_WAITING);
    if (sv_mode == MODE_RUNNING) begin
      if (c.button) switch_mode(MODE_WAITING);
      return;
    end
    if (sv_mode == MODE_WAITING && c.button && sv_cam) switch_mode(MODE_RUNNING);
  endfunction

  // Advances the shadow by one command and returns the report it produces.
  function automatic report_t next_report(command_t c);
    report_t r;
    r = '0;
    r.verdict = RES_ACCEPTED;
    st_motor = 1'b0;
    st_servo = 1'b0;
    st_boot  = 1'b0;
    case (c.cmd)
      CMD_SERVICE: service_tick(c);
      CMD_INIT_DONE: begin
        sv_cam   = 1'b0;
        sv_armed = 1'b0;
        sv_pend  = 1'b0;
        sv_mode  = MODE_STARTUP;
        sv_fault = FAULT_NONE;
        sv_isp_t = '0;
        sv_ready = 1'b1;
        if (c.test_sw) switch_mode(MODE_TEST);
        else switch_mode(MODE_WAITING);
      end
      CMD_CAMERA: sv_cam = 1'b1;
      CMD_STOP: begin
        st_motor = 1'b1;
        st_servo = 1'b1;
        sv_armed = 1'b0;
        sv_pend  = 1'b0;
        if (sv_mode == MODE_RUNNING) switch_mode(MODE_WAITING);
      end
      CMD_RACE: begin
        if (c.test_sw || sv_mode != MODE_WAITING) r.verdict = RES_DENIED;
        else if (!sv_cam) r.verdict = RES_NOT_READY;
        else switch_mode(MODE_RUNNING);
      end
      CMD_FAULT: begin
        // Codes beyond the known set latch as no fault.
        sv_fault = (c.fault_code <= FAULT_BOOT_RETURNED) ? c.fault_code : FAULT_NONE;
        switch_mode(MODE_FAULT);
      end
      default: r.verdict = RES_DENIED;
    endcase
    r.mode    = sv_mode;
    r.status  = status_of();
    r.allowed = (sv_mode == MODE_RUNNING) || (sv_mode == MODE_TEST && sv_armed);
    r.motor   = st_motor;
    r.servo   = st_servo;
    r.boot    = st_boot;
    r.fault   = sv_fault;
    r.cam     = sv_cam;
    r.armed   = sv_armed;
    r.pend    = sv_pend;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Report checker and receiver stall.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $error("report beat with no command outstanding");
        fails++;
      end else begin
        want_r = expected_reports.pop_front();
        check_field("mode", 32'(want_r.mode), 32'(mode_o));
        check_field("status", 32'(want_r.status), 32'(status_o));
        check_field("action_result", 32'(want_r.verdict), 32'(action_result_o));
        check_field("outputs_allowed", 32'(want_r.allowed), 32'(outputs_allowed_o));
        check_field("motor_disable", 32'(want_r.motor), 32'(motor_disable_o));
        check_field("servo_center", 32'(want_r.servo), 32'(servo_center_o));
        check_field("boot_request", 32'(want_r.boot), 32'(boot_request_o));
        check_field("fault", 32'(want_r.fault), 32'(fault_o));
        check_field("camera_seen", 32'(want_r.cam), 32'(camera_seen_o));
        check_field("test_armed", 32'(want_r.armed), 32'(test_armed_o));
        check_field("arm_pending", 32'(want_r.pend), 32'(arm_pending_o));
      end
    end
  end

  // A requested hold-off wins; otherwise random stalls unless quiet.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------
  // Leaves valid high after the beat; the next call or a drain decides.
  task automatic send_command(command_t c);
    int gap;
    gap = 0;
    if (!quiet) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= c.cmd;
    test_switch_i    <= c.test_sw;
    button_release_i <= c.button;
    pot_a_i          <= c.pot_a;
    pot_b_i          <= c.pot_b;
    pot_c_i          <= c.pot_c;
    isp_request_i    <= c.isp_req;
    tx_idle_i        <= c.tx_idle;
    now_ms_i         <= c.now_ms;
    fault_code_i     <= c.fault_code;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    expected_reports.push_back(next_report(c));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg valid high; configure() drops it after the last write.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    case (idx)
      CFG_ISP_SETTLE:   cfg_settle = data;
      CFG_ISP_MAX_WAIT: cfg_max_wait = data;
      CFG_POT_LOW:      cfg_pot_lo = data[11:0];
      CFG_POT_HIGH:     cfg_pot_hi = data[11:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] settle, logic [15:0] max_wait,
                           logic [11:0] lo, logic [11:0] hi);
    wait_drained();
    write_reg(CFG_ISP_SETTLE, settle);
    write_reg(CFG_ISP_MAX_WAIT, max_wait);
    write_reg(CFG_POT_LOW, {4'b0, lo});
    write_reg(CFG_POT_HIGH, {4'b0, hi});
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Command generation.
  // ---------------------------------------------------------------------------
  function automatic command_t op_cmd(logic [2:0] op, logic tsw, logic btn);
    command_t c;
    c = '0;
    c.cmd = op;
    c.test_sw = tsw;
    c.button = btn;
    c.pot_a = 12'd2048;
    c.pot_b = 12'd2048;
    c.pot_c = 12'd2048;
    c.fault_code = FAULT_NONE;
    return c;
  endfunction

  // Mostly inside the window so arming happens, with window edges and rails.
  function automatic logic [11:0] pot_reading();
    int lo, hi;
    logic [11:0] v;
    lo = cfg_pot_lo;
    hi = cfg_pot_hi;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = (hi > lo + 1) ? 12'($urandom_range(hi - 1, lo + 1))
                                       : 12'($urandom_range(4095));
      5: v = cfg_pot_lo;
      6: v = cfg_pot_hi;
      7: v = $urandom_range(1) ? 12'd4095 : 12'd0;
      default: v = 12'($urandom_range(4095));
    endcase
    return v;
  endfunction

  function automatic command_t random_command();
    command_t c;
    int r;
    c = '0;
    // Pure noise: every field at random.
    if ($urandom_range(99) < 8) begin
      c.cmd        = 3'($urandom_range(7));
      c.test_sw    = 1'($urandom_range(1));
      c.button     = 1'($urandom_range(1));
      c.pot_a      = 12'($urandom_range(4095));
      c.pot_b      = 12'($urandom_range(4095));
      c.pot_c      = 12'($urandom_range(4095));
      c.isp_req    = 1'($urandom_range(1));
      c.tx_idle    = 1'($urandom_range(1));
      c.now_ms     = $urandom();
      c.fault_code = 3'($urandom_range(7));
      return c;
    end
    // Coherent sequence: sticky switch, monotonic clock with rare big jumps.
    if ($urandom_range(99) < 8) tb_switch = !tb_switch;
    r = $urandom_range(99);
    if (r < 85) tb_clock_ms = tb_clock_ms + $urandom_range(150);
    else if (r < 97) tb_clock_ms = tb_clock_ms + $urandom_range(70000, 150);
    else tb_clock_ms = tb_clock_ms + $urandom();
    c.now_ms     = tb_clock_ms;
    c.test_sw    = tb_switch;
    c.button     = ($urandom_range(99) < 18);
    c.pot_a      = pot_reading();
    c.pot_b      = pot_reading();
    c.pot_c      = pot_reading();
    c.isp_req    = ($urandom_range(99) < 3);
    c.tx_idle    = ($urandom_range(99) < 35);
    c.fault_code = 3'($urandom_range(7));
    r = $urandom_range(99);
    if (r < 55) c.cmd = CMD_SERVICE;
    else if (r < 61) c.cmd = CMD_INIT_DONE;
    else if (r < 69) c.cmd = CMD_CAMERA;
    else if (r < 75) c.cmd = CMD_STOP;
    else if (r < 92) c.cmd = CMD_RACE;
    else if (r < 96) c.cmd = CMD_FAULT;
    else c.cmd = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
    return c;
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_command(random_command());
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    command_t c;
    // Before init: tick into test mode gives no strobes.
    c = op_cmd(CMD_SERVICE, 1'b1, 1'b0);
    c.now_ms = 32'hFFFF_FFFF;
    send_command(c);
    // Boot request before init still strobes.
    c = op_cmd(CMD_SERVICE, 1'b0, 1'b0);
    c.isp_req = 1'b1;
    send_command(c);
    send_command(op_cmd(CMD_INIT_DONE, 1'b0, 1'b0));
    send_command(op_cmd(CMD_RACE, 1'b0, 1'b0));       // no camera yet
    send_command(op_cmd(CMD_RACE, 1'b1, 1'b0));       // switch on: denied
    send_command(op_cmd(CMD_CAMERA, 1'b0, 1'b0));
    send_command(op_cmd(CMD_RACE, 1'b0, 1'b0));       // accepted
    send_command(op_cmd(CMD_STOP, 1'b0, 1'b0));
    send_command(op_cmd(CMD_SERVICE, 1'b0, 1'b1));    // button starts race
    send_command(op_cmd(CMD_SERVICE, 1'b0, 1'b1));    // button stops race
    send_command(op_cmd(CMD_INIT_DONE, 1'b1, 1'b0));
    // Arm request with pots off centre, then centred just inside the edges.
    c = op_cmd(CMD_SERVICE, 1'b1, 1'b1);
    c.pot_a = 12'd0;
    c.pot_b = 12'd4095;
    c.pot_c = 12'd0;
    send_command(c);
    c = op_cmd(CMD_SERVICE, 1'b1, 1'b0);
    c.pot_a = 12'd1844;
    c.pot_b = 12'd2251;
    send_command(c);
    send_command(op_cmd(CMD_SERVICE, 1'b1, 1'b1));    // release disarms
    c = op_cmd(CMD_SERVICE, 1'b1, 1'b1);
    c.pot_a = 12'd1843;                               // on the edge: not centred
    c.pot_b = 12'd2252;
    send_command(c);
    send_command(op_cmd(CMD_SERVICE, 1'b0, 1'b0));    // leave test mode
    // Boot entry across the 32-bit wrap: settle, transmit busy, max wait.
    c = op_cmd(CMD_SERVICE, 1'b0, 1'b0);
    c.isp_req = 1'b1;
    c.now_ms = 32'hFFFF_FFC0;
    send_command(c);
    c = op_cmd(CMD_SERVICE, 1'b0, 1'b0);
    c.tx_idle = 1'b1;
    c.now_ms = 32'hFFFF_FFE8;
    send_command(c);
    c.tx_idle = 1'b0;
    c.now_ms = 32'd50;
    send_command(c);
    c.now_ms = 32'd436;
    send_command(c);
    send_command(op_cmd(CMD_SERVICE, 1'b1, 1'b1));    // tick in safe fault
    c = op_cmd(CMD_FAULT, 1'b0, 1'b0);
    c.fault_code = FAULT_BAD_CODE;
    send_command(c);
    c.fault_code = FAULT_CAM_LOST;
    send_command(c);
    send_command(op_cmd(CMD_SPARE_6, 1'b0, 1'b0));
    send_command(op_cmd(CMD_SPARE_7, 1'b1, 1'b1));
    send_command(op_cmd(CMD_RACE, 1'b0, 1'b0));       // denied in fault
  endtask

  task automatic test_steady_flow();
    quiet = 1'b1;
    send_random(300);
    quiet = 1'b0;
  endtask

  // Receiver holds off long enough for the pipe to fill and stall the input.
  task automatic test_backpressure();
    wait_drained();
    quiet = 1'b1;
    rx_hold = 300;
    send_random(40);
    quiet = 1'b0;
  endtask

  task automatic test_sender_pause();
    send_random(30);
    wait_drained();
    send_random(30);
  endtask

  task automatic test_config_sweep();
    configure(16'd0, 16'd0, 12'd0, 12'd4095);
    send_random(150);
    configure(16'hFFFF, 16'hFFFF, 12'd4095, 12'd0);
    send_random(150);
    configure(16'd0, 16'hFFFF, 12'd2047, 12'd2048);   // empty window
    send_random(150);
    configure(16'hFFFF, 16'd0, 12'd0, 12'd0);
    send_random(150);
    configure(16'($urandom_range(65535)), 16'($urandom_range(65535)),
              12'($urandom_range(2047)), 12'($urandom_range(4095, 2048)));
    send_random(150);
    configure(ISP_SETTLE_RST, ISP_MAX_WAIT_RST, POT_LOW_RST, POT_HIGH_RST);
    send_random(150);
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 650; i++) begin
      send_command(random_command());
      if ($urandom_range(99) == 0) wait_drained();
    end
  endtask

  initial begin
    tb_clock_ms = $urandom();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_directed();
    test_steady_flow();
    test_backpressure();
    test_sender_pause();
    test_config_sweep();
    test_random_mix();
    wait_drained();

    if (fails == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ams_pkg.sv
hw/rtl/actuator_mode_supervisor_top.sv
sim/tb_top.sv
